[design/pressure_sensor_compensation_assert.svh]
// ---------------------------------------------------------------------------
// Pressure sensor compensation assertion macros
// Concurrent assertion shorthands clocked by clock and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef PRESSURE_SENSOR_COMPENSATION_ASSERT_SVH
`define PRESSURE_SENSOR_COMPENSATION_ASSERT_SVH

// The condition implies the expression in the same cycle.
`define PSC_ASSERT_SAME(name, cond, expr) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("Pipeline check failed in the same cycle.");

// The condition implies the expression in the next cycle.
`define PSC_ASSERT_NEXT(name, cond, expr) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("Pipeline check failed in the next cycle.");

`endif

[design/psc_pkg.sv]
// ---------------------------------------------------------------------------
// Pressure sensor compensation package
// Widths, scaling shifts, limits, register indexes and shared types.
// ---------------------------------------------------------------------------
package psc_pkg;

   localparam int STAGES = 9;

   localparam int RAW_W = 24;
   localparam int CAL_W = 16;
   localparam int DT_W = 25;
   localparam int PRD_W = 42;
   localparam int DSQ_W = 48;
   localparam int Q_W = 18;
   localparam int OFF_W = 35;
   localparam int SENS_W = 34;
   localparam int TI_W = 17;
   localparam int SQ_W = 34;
   localparam int OFFI_W = 35;
   localparam int SENSI_W = 34;
   localparam int T2_W = 20;
   localparam int OFF2_W = 37;
   localparam int SENS2_W = 36;
   localparam int SPLIT_W = 18;
   localparam int PPLO_W = 42;
   localparam int PPHI_W = 43;
   localparam int PROD_W = 61;
   localparam int DIFF_W = 41;
   localparam int TEMP_OUT_W = 15;
   localparam int PRESS_OUT_W = 19;
   localparam int CSR_IDX_W = 3;

   localparam int REF_SHIFT = 8;
   localparam int TEMP_SHIFT = 23;
   localparam int OFF_SHIFT = 7;
   localparam int SENS_SHIFT = 8;
   localparam int OFF_BASE_SHIFT = 16;
   localparam int SENS_BASE_SHIFT = 15;
   localparam int TI_LOW_SHIFT = 33;
   localparam int TI_HIGH_SHIFT = 36;
   localparam int PRESS_SHIFT = 21;
   localparam int OUT_SHIFT = 13;
   localparam int P_W = DIFF_W - OUT_SHIFT;

   localparam logic signed [T2_W-1:0] TEMP_BASE = T2_W'(2000);
   localparam logic signed [T2_W-1:0] TEMP_MIN = -T2_W'(4000);
   localparam logic signed [T2_W-1:0] TEMP_MAX = T2_W'(8500);
   localparam logic signed [P_W-1:0] PRESS_MAX = P_W'(300000);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PRESSURE_SENSITIVITY  = 3'd0,
      CSR_PRESSURE_OFFSET       = 3'd1,
      CSR_SENS_TEMP_COEFF       = 3'd2,
      CSR_OFFSET_TEMP_COEFF     = 3'd3,
      CSR_REFERENCE_TEMPERATURE = 3'd4,
      CSR_TEMPERATURE_COEFF     = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [CAL_W-1:0] pressure_sensitivity;
      logic [CAL_W-1:0] pressure_offset;
      logic [CAL_W-1:0] sens_temp_coeff;
      logic [CAL_W-1:0] offset_temp_coeff;
      logic [CAL_W-1:0] reference_temperature;
      logic [CAL_W-1:0] temperature_coeff;
   } psc_cal_type;

   typedef struct packed {
      logic [STAGES-1:0] vld;
      logic [STAGES-1:0] load;
   } psc_ctrl_type;

   typedef struct packed {
      logic signed [T2_W-1:0]    t2;
      logic signed [OFF2_W-1:0]  off2;
      logic signed [SENS2_W-1:0] sens2;
      logic [RAW_W-1:0]          d1;
   } psc_terms_type;

endpackage

[design/psc_if.sv]
// ---------------------------------------------------------------------------
// Pressure sensor compensation channels
// Valid/ready interfaces for the raw sample and the compensated result.
// ---------------------------------------------------------------------------
interface psc_req_if import psc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [RAW_W-1:0] raw_pressure;
   logic [RAW_W-1:0] raw_temperature;

   modport source (output valid, output raw_pressure, output raw_temperature, input ready);
   modport sink (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface psc_rsp_if import psc_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [TEMP_OUT_W-1:0]  temperature_centideg;
   logic [PRESS_OUT_W-1:0]        pressure_decimbar;
   logic                          clipped;

   modport source (output valid, output temperature_centideg, output pressure_decimbar,
                   output clipped, input ready);
   modport sink (input valid, input temperature_centideg, input pressure_decimbar,
                 input clipped, output ready);
endinterface

[design/psc_pipe_ctrl.sv]
// ---------------------------------------------------------------------------
// Pressure sensor compensation pipeline control
// Tracks the valid bit of every stage and computes per-stage load enables.
// ---------------------------------------------------------------------------
`include "pressure_sensor_compensation_assert.svh"

module psc_pipe_ctrl import psc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         rsp_ready,
   output psc_ctrl_type ctrl
);

   logic [STAGES-1:0] vld_ff;
   logic [STAGES-1:0] vld_in;
   logic [STAGES-1:0] load;
   logic              acc_in;
   logic              acc_out;

   // A stage loads when empty or when the stage after it loads; the last stage also loads when rsp_ready is high.
   always_comb begin
      load[STAGES-1] = !vld_ff[STAGES-1] || rsp_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         load[k] = !vld_ff[k] || load[k+1];
      end
   end

   assign vld_in = (({vld_ff[STAGES-2:0], req_valid}) & load) | (vld_ff & ~load);
   assign acc_in = req_valid && load[0];
   assign acc_out = vld_ff[STAGES-1] && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign ctrl.vld = vld_ff;
   assign ctrl.load = load;

   `PSC_ASSERT_SAME(a_rsp_ready_frees_input, rsp_ready, load[0])
   `PSC_ASSERT_NEXT(a_accept_fills_first, acc_in, vld_ff[0])
   `PSC_ASSERT_NEXT(a_item_count, !reset,
      $countones(vld_ff) == $countones($past(vld_ff)) + $past(acc_in) - $past(acc_out))

endmodule

[design/psc_comp.sv]
// ---------------------------------------------------------------------------
// Pressure sensor compensation terms
// Stages zero to four: temperature difference, first-order terms and the
// second-order correction of temperature, offset and sensitivity.
// ---------------------------------------------------------------------------
module psc_comp import psc_pkg::*; (
   input  logic              clock,
   input  psc_ctrl_type      ctrl,
   input  psc_cal_type       cal,
   input  logic [RAW_W-1:0]  raw_pressure,
   input  logic [RAW_W-1:0]  raw_temperature,
   output psc_terms_type     terms
);

   // Stage 0.
   logic signed [DT_W-1:0]     dt_in, dt_s0_ff;
   logic [RAW_W-1:0]           d1_s0_ff;
   // Stage 1.
   logic signed [PRD_W-1:0]    pt_in, pt_s1_ff;
   logic signed [PRD_W-1:0]    po_in, po_s1_ff;
   logic signed [PRD_W-1:0]    ps_in, ps_s1_ff;
   logic signed [2*DT_W-1:0]   dd_full;
   logic [DSQ_W-1:0]           dd_in, dd_s1_ff;
   logic [RAW_W-1:0]           d1_s1_ff;
   // Stage 2.
   logic signed [PRD_W-1:0]    pt_bias, po_bias, ps_bias;
   logic [DSQ_W+1:0]           dd3;
   logic [TI_W-1:0]            ti_lo, ti_hi;
   logic signed [Q_W-1:0]      q_in, q_s2_ff;
   logic signed [OFF_W-1:0]    off_in, off_s2_ff;
   logic signed [SENS_W-1:0]   sens_in, sens_s2_ff;
   logic [TI_W-1:0]            ti_in, ti_s2_ff;
   logic [RAW_W-1:0]           d1_s2_ff;
   // Stage 3.
   logic signed [2*Q_W-1:0]    sq_full;
   logic [SQ_W-1:0]            sq_in, sq_s3_ff;
   logic signed [Q_W-1:0]      q_s3_ff;
   logic signed [OFF_W-1:0]    off_s3_ff;
   logic signed [SENS_W-1:0]   sens_s3_ff;
   logic [TI_W-1:0]            ti_s3_ff;
   logic [RAW_W-1:0]           d1_s3_ff;
   // Stage 4.
   logic [SQ_W+1:0]            sq3;
   logic [SQ_W+2:0]            sq5;
   logic [OFFI_W-1:0]          offi;
   logic [SENSI_W-1:0]         sensi;
   logic                       low;
   psc_terms_type              terms_in, terms_s4_ff;

   assign dt_in = $signed({1'b0, raw_temperature})
                - $signed({1'b0, cal.reference_temperature, {REF_SHIFT{1'b0}}});

   assign pt_in = dt_s0_ff * $signed({1'b0, cal.temperature_coeff});
   assign po_in = dt_s0_ff * $signed({1'b0, cal.offset_temp_coeff});
   assign ps_in = dt_s0_ff * $signed({1'b0, cal.sens_temp_coeff});
   assign dd_full = dt_s0_ff * dt_s0_ff;
   assign dd_in = dd_full[DSQ_W-1:0];

   // Negative values get a bias so that the shifts round toward zero.
   assign pt_bias = pt_s1_ff + $signed({{(PRD_W-TEMP_SHIFT){1'b0}},
                                        {TEMP_SHIFT{pt_s1_ff[PRD_W-1]}}});
   assign po_bias = po_s1_ff + $signed({{(PRD_W-OFF_SHIFT){1'b0}},
                                        {OFF_SHIFT{po_s1_ff[PRD_W-1]}}});
   assign ps_bias = ps_s1_ff + $signed({{(PRD_W-SENS_SHIFT){1'b0}},
                                        {SENS_SHIFT{ps_s1_ff[PRD_W-1]}}});
   assign q_in = $signed(pt_bias[TEMP_SHIFT+Q_W-1:TEMP_SHIFT]);
   assign off_in = $signed({{(OFF_W-CAL_W-OFF_BASE_SHIFT){1'b0}}, cal.pressure_offset,
                            {OFF_BASE_SHIFT{1'b0}}})
                 + $signed(po_bias[PRD_W-1:OFF_SHIFT]);
   assign sens_in = $signed({{(SENS_W-CAL_W-SENS_BASE_SHIFT){1'b0}},
                             cal.pressure_sensitivity, {SENS_BASE_SHIFT{1'b0}}})
                  + $signed(ps_bias[PRD_W-1:SENS_SHIFT]);
   assign dd3 = {2'b00, dd_s1_ff} + {1'b0, dd_s1_ff, 1'b0};
   assign ti_lo = dd3[TI_LOW_SHIFT+TI_W-1:TI_LOW_SHIFT];
   assign ti_hi = {{(TI_W-(DSQ_W-TI_HIGH_SHIFT)){1'b0}}, dd_s1_ff[DSQ_W-1:TI_HIGH_SHIFT]};
   assign ti_in = q_in[Q_W-1] ? ti_lo : ti_hi;

   assign sq_full = q_s2_ff * q_s2_ff;
   assign sq_in = sq_full[SQ_W-1:0];

   // The low branch applies below the base temperature, where q is negative.
   assign low = q_s3_ff[Q_W-1];
   assign sq3 = {2'b00, sq_s3_ff} + {1'b0, sq_s3_ff, 1'b0};
   assign sq5 = {3'b000, sq_s3_ff} + {1'b0, sq_s3_ff, 2'b00};
   assign offi = low ? sq3[SQ_W+1:1] : {5'b00000, sq_s3_ff[SQ_W-1:4]};
   assign sensi = low ? sq5[SQ_W+2:3] : '0;

   always_comb begin
      terms_in.t2 = TEMP_BASE + T2_W'(q_s3_ff) - $signed({{(T2_W-TI_W){1'b0}}, ti_s3_ff});
      terms_in.off2 = OFF2_W'(off_s3_ff) - $signed({{(OFF2_W-OFFI_W){1'b0}}, offi});
      terms_in.sens2 = SENS2_W'(sens_s3_ff) - $signed({{(SENS2_W-SENSI_W){1'b0}}, sensi});
      terms_in.d1 = d1_s3_ff;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         dt_s0_ff <= dt_in;
         d1_s0_ff <= raw_pressure;
      end
      if (ctrl.load[1]) begin
         pt_s1_ff <= pt_in;
         po_s1_ff <= po_in;
         ps_s1_ff <= ps_in;
         dd_s1_ff <= dd_in;
         d1_s1_ff <= d1_s0_ff;
      end
      if (ctrl.load[2]) begin
         q_s2_ff <= q_in;
         off_s2_ff <= off_in;
         sens_s2_ff <= sens_in;
         ti_s2_ff <= ti_in;
         d1_s2_ff <= d1_s1_ff;
      end
      if (ctrl.load[3]) begin
         sq_s3_ff <= sq_in;
         q_s3_ff <= q_s2_ff;
         off_s3_ff <= off_s2_ff;
         sens_s3_ff <= sens_s2_ff;
         ti_s3_ff <= ti_s2_ff;
         d1_s3_ff <= d1_s2_ff;
      end
      if (ctrl.load[4]) begin
         terms_s4_ff <= terms_in;
      end
   end

   assign terms = terms_s4_ff;

endmodule

[design/psc_press.sv]
// ---------------------------------------------------------------------------
// Pressure sensor compensation pressure scaling
// Stages five to eight: split raw pressure times sensitivity, offset removal,
// final scaling and saturation of both results.
// ---------------------------------------------------------------------------
module psc_press import psc_pkg::*; (
   input  logic                          clock,
   input  psc_ctrl_type                  ctrl,
   input  psc_terms_type                 terms,
   output logic signed [TEMP_OUT_W-1:0]  temperature_centideg,
   output logic [PRESS_OUT_W-1:0]        pressure_decimbar,
   output logic                          clipped
);

   // Stage 5.
   logic [SPLIT_W-1:0]                 sens_lo;
   logic signed [SENS2_W-SPLIT_W-1:0]  sens_hi;
   logic [PPLO_W-1:0]                  pplo_in, pplo_s5_ff;
   logic signed [PPHI_W-1:0]           pphi_in, pphi_s5_ff;
   logic signed [T2_W-1:0]             t2_s5_ff, t2_s6_ff, t2_s7_ff;
   logic signed [OFF2_W-1:0]           off2_s5_ff, off2_s6_ff;
   // Stage 6.
   logic signed [PROD_W-1:0]           prod_in, prod_s6_ff;
   // Stage 7.
   logic signed [PROD_W-1:0]           prod_bias;
   logic signed [PROD_W-PRESS_SHIFT-1:0] scaled;
   logic signed [DIFF_W-1:0]           diff_in, diff_s7_ff;
   // Stage 8.
   logic signed [DIFF_W-1:0]           diff_bias;
   logic signed [P_W-1:0]              p;
   logic signed [T2_W-1:0]             t2_sat;
   logic signed [P_W-1:0]              p_sat;
   logic                               t_clip, p_clip;
   logic signed [TEMP_OUT_W-1:0]       temp_in, temp_s8_ff;
   logic [PRESS_OUT_W-1:0]             press_in, press_s8_ff;
   logic                               clip_in, clip_s8_ff;

   assign sens_lo = terms.sens2[SPLIT_W-1:0];
   assign sens_hi = $signed(terms.sens2[SENS2_W-1:SPLIT_W]);
   assign pplo_in = terms.d1 * sens_lo;
   assign pphi_in = $signed({1'b0, terms.d1}) * sens_hi;

   assign prod_in = $signed({pphi_s5_ff, {SPLIT_W{1'b0}}})
                  + $signed({{(PROD_W-PPLO_W){1'b0}}, pplo_s5_ff});

   assign prod_bias = prod_s6_ff + $signed({{(PROD_W-PRESS_SHIFT){1'b0}},
                                            {PRESS_SHIFT{prod_s6_ff[PROD_W-1]}}});
   assign scaled = $signed(prod_bias[PROD_W-1:PRESS_SHIFT]);
   assign diff_in = DIFF_W'(scaled) - DIFF_W'(off2_s6_ff);

   assign diff_bias = diff_s7_ff + $signed({{(DIFF_W-OUT_SHIFT){1'b0}},
                                            {OUT_SHIFT{diff_s7_ff[DIFF_W-1]}}});
   assign p = $signed(diff_bias[DIFF_W-1:OUT_SHIFT]);

   always_comb begin
      t2_sat = t2_s7_ff;
      t_clip = 1'b0;
      priority if (t2_s7_ff < TEMP_MIN) begin
         t2_sat = TEMP_MIN;
         t_clip = 1'b1;
      end else if (t2_s7_ff > TEMP_MAX) begin
         t2_sat = TEMP_MAX;
         t_clip = 1'b1;
      end else begin
         t2_sat = t2_s7_ff;
      end
      p_sat = p;
      p_clip = 1'b0;
      priority if (p[P_W-1]) begin
         p_sat = '0;
         p_clip = 1'b1;
      end else if (p > PRESS_MAX) begin
         p_sat = PRESS_MAX;
         p_clip = 1'b1;
      end else begin
         p_sat = p;
      end
      temp_in = t2_sat[TEMP_OUT_W-1:0];
      press_in = p_sat[PRESS_OUT_W-1:0];
      clip_in = t_clip || p_clip;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[5]) begin
         pplo_s5_ff <= pplo_in;
         pphi_s5_ff <= pphi_in;
         t2_s5_ff <= terms.t2;
         off2_s5_ff <= terms.off2;
      end
      if (ctrl.load[6]) begin
         prod_s6_ff <= prod_in;
         t2_s6_ff <= t2_s5_ff;
         off2_s6_ff <= off2_s5_ff;
      end
      if (ctrl.load[7]) begin
         diff_s7_ff <= diff_in;
         t2_s7_ff <= t2_s6_ff;
      end
      if (ctrl.load[8]) begin
         temp_s8_ff <= temp_in;
         press_s8_ff <= press_in;
         clip_s8_ff <= clip_in;
      end
   end

   assign temperature_centideg = temp_s8_ff;
   assign pressure_decimbar = press_s8_ff;
   assign clipped = clip_s8_ff;

endmodule

[design/pressure_sensor_compensation.sv]
// ---------------------------------------------------------------------------
// Pressure sensor second-order temperature compensation, top level
// A sample moves through the stage registers in order; rsp valid rises when it
// reaches the last. One transaction per cycle while rsp ready does not stall;
// the nine stages hold nine samples.
// Reset clears all stage valid bits and the six calibration words to zero.
// ---------------------------------------------------------------------------
module pressure_sensor_compensation import psc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   psc_req_if.sink              req_if,
   psc_rsp_if.source            rsp_if,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CAL_W-1:0]     csr_wdata
);

   psc_cal_type   cal_ff, cal_in;
   psc_ctrl_type  ctrl;
   psc_terms_type terms;

   always_comb begin
      cal_in = cal_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_PRESSURE_SENSITIVITY:  cal_in.pressure_sensitivity = csr_wdata;
            CSR_PRESSURE_OFFSET:       cal_in.pressure_offset = csr_wdata;
            CSR_SENS_TEMP_COEFF:       cal_in.sens_temp_coeff = csr_wdata;
            CSR_OFFSET_TEMP_COEFF:     cal_in.offset_temp_coeff = csr_wdata;
            CSR_REFERENCE_TEMPERATURE: cal_in.reference_temperature = csr_wdata;
            CSR_TEMPERATURE_COEFF:     cal_in.temperature_coeff = csr_wdata;
            default:                   cal_in = cal_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= '0;
      end else begin
         cal_ff <= cal_in;
      end
   end

   psc_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .rsp_ready (rsp_if.ready),
      .ctrl      (ctrl)
   );

   psc_comp u_comp (
      .clock           (clock),
      .ctrl            (ctrl),
      .cal             (cal_ff),
      .raw_pressure    (req_if.raw_pressure),
      .raw_temperature (req_if.raw_temperature),
      .terms           (terms)
   );

   psc_press u_press (
      .clock                (clock),
      .ctrl                 (ctrl),
      .terms                (terms),
      .temperature_centideg (rsp_if.temperature_centideg),
      .pressure_decimbar    (rsp_if.pressure_decimbar),
      .clipped              (rsp_if.clipped)
   );

   assign req_if.ready = ctrl.load[0];
   assign rsp_if.valid = ctrl.vld[STAGES-1];

endmodule
